FILE: src/bra_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator package
// Shared constants and types for the first-fit bitmap run allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

   localparam int MapBytes  = 512;
   localparam int AddrWidth = $clog2(MapBytes);
   localparam int SizeWidth = 10;

   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_TEST  = 2'd1,
      ACT_SET   = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_NO_ROOM = 2'd1,
      ST_BAD     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_SCAN,
      FSM_MARK,
      FSM_BIT,
      FSM_OUT
   } fsm_type;

   typedef struct packed {
      logic                 rd_en;
      logic [AddrWidth-1:0] rd_addr;
      logic                 wr_en;
      logic [AddrWidth-1:0] wr_addr;
      logic [7:0]           wr_data;
   } mem_ctl_type;

endpackage

FILE: src/bra_map_ram.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator map memory
// One-read, one-write byte memory holding the usage bit map.
// ----------------------------------------------------------------------------
module bra_map_ram
   import bra_pkg::*;
(
   input  logic        clock,
   input  mem_ctl_type ctl,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [MapBytes];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/bitmap_run_allocator_core.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator core
// First-fit allocator of runs of free units over a byte-wide bit map.
// A bad request answers in the cycle after acceptance; test, set and clear
// pass through the bit state first. Allocation scans one unit per cycle and
// then marks one unit per cycle.
// One transaction at a time; the next request is taken after the response.
// Reset clears the map, byte by byte, before the first request.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_core
   import bra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[1:0], bit_index[13:2], count[26:14], zero pad[31:27]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], start_index[13:2], bit_is_used[14], zero pad[15]
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [9:0]  csr_wdata
);

   fsm_type                state_ff, state_in;
   logic [SizeWidth-1:0]   size_ff;
   logic [AddrWidth-1:0]   clr_ff, clr_in;
   action_type             act_ff, act_in;
   logic [11:0]            idx_ff, idx_in;
   logic [12:0]            cnt_ff, cnt_in;
   logic [12:0]            n_ff, n_in;
   logic [12:0]            run_ff, run_in;
   logic [12:0]            k_ff, k_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   fwd_ff, fwd_in;
   status_type             st_ff, st_in;
   logic [11:0]            start_ff, start_in;
   logic                   used_ff, used_in;
   mem_ctl_type            ctl;
   logic [7:0]             rd_data, cur_byte;
   logic [12:0]            total;

   bra_map_ram u_ram (.clock(clock), .ctl(ctl), .rd_data(rd_data));

   assign total    = {size_ff, 3'b000};
   assign cur_byte = fwd_ff ? byte_ff : rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SizeWidth'(MapBytes);
      end else if (csr_we) begin
         if (csr_wdata == '0) begin
            size_ff <= SizeWidth'(1);
         end else if (csr_wdata > SizeWidth'(MapBytes)) begin
            size_ff <= SizeWidth'(MapBytes);
         end else begin
            size_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      act_ff   <= act_in;
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      n_ff     <= n_in;
      run_ff   <= run_in;
      k_ff     <= k_in;
      byte_ff  <= byte_in;
      fwd_ff   <= fwd_in;
      st_ff    <= st_in;
      start_ff <= start_in;
      used_ff  <= used_in;
   end

   // The scan reads byte n>>3 when entering a new byte; within a byte the
   // registered copy in byte_ff is used (fwd_ff).
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      act_in   = act_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      n_in     = n_ff;
      run_in   = run_ff;
      k_in     = k_ff;
      byte_in  = byte_ff;
      fwd_in   = fwd_ff;
      st_in    = st_ff;
      start_in = start_ff;
      used_in  = used_ff;
      ctl      = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         FSM_CLEAR: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = clr_ff;
            ctl.wr_data = 8'h00;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == AddrWidth'(MapBytes - 1)) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               act_in   = action_type'(req_tdata[1:0]);
               idx_in   = req_tdata[13:2];
               cnt_in   = req_tdata[26:14];
               st_in    = ST_DONE;
               start_in = '0;
               used_in  = 1'b0;
               n_in     = '0;
               run_in   = '0;
               fwd_in   = 1'b0;
               if (action_type'(req_tdata[1:0]) == ACT_ALLOC) begin
                  if (req_tdata[26:14] == '0) begin
                     st_in    = ST_BAD;
                     state_in = FSM_OUT;
                  end else begin
                     ctl.rd_en   = 1'b1;
                     ctl.rd_addr = '0;
                     state_in    = FSM_SCAN;
                  end
               end else if ({1'b0, req_tdata[13:2]} >= total) begin
                  st_in    = ST_BAD;
                  state_in = FSM_OUT;
               end else begin
                  ctl.rd_en   = 1'b1;
                  ctl.rd_addr = req_tdata[13:5];
                  state_in    = FSM_BIT;
               end
            end
         end
         FSM_BIT: begin
            if (act_ff == ACT_TEST) begin
               used_in = rd_data[idx_ff[2:0]];
            end else begin
               ctl.wr_en   = 1'b1;
               ctl.wr_addr = idx_ff[11:3];
               ctl.wr_data = rd_data;
               ctl.wr_data[idx_ff[2:0]] = (act_ff == ACT_SET);
            end
            state_in = FSM_OUT;
         end
         FSM_SCAN: begin
            byte_in = cur_byte;
            fwd_in  = 1'b1;
            if (cur_byte[n_ff[2:0]]) begin
               run_in = '0;
            end else begin
               run_in = run_ff + 1'b1;
            end
            if (!cur_byte[n_ff[2:0]] && (run_ff + 1'b1 == cnt_ff)) begin
               start_in = 12'(n_ff + 1'b1 - cnt_ff);
               k_in     = n_ff + 1'b1 - cnt_ff;
               ctl.rd_en   = 1'b1;
               ctl.rd_addr = k_in[11:3];
               fwd_in   = 1'b0;
               state_in = FSM_MARK;
            end else if (n_ff + 1'b1 >= total) begin
               st_in    = ST_NO_ROOM;
               state_in = FSM_OUT;
            end else begin
               n_in = n_ff + 1'b1;
               if (n_ff[2:0] == 3'd7) begin
                  ctl.rd_en   = 1'b1;
                  ctl.rd_addr = n_in[11:3];
                  fwd_in      = 1'b0;
               end
            end
         end
         FSM_MARK: begin
            byte_in = cur_byte;
            byte_in[k_ff[2:0]] = 1'b1;
            fwd_in  = 1'b1;
            if (k_ff == n_ff || k_ff[2:0] == 3'd7) begin
               ctl.wr_en   = 1'b1;
               ctl.wr_addr = k_ff[11:3];
               ctl.wr_data = byte_in;
               fwd_in      = 1'b0;
            end
            if (k_ff == n_ff) begin
               state_in = FSM_OUT;
            end else begin
               k_in = k_ff + 1'b1;
               if (k_ff[2:0] == 3'd7) begin
                  ctl.rd_en   = 1'b1;
                  ctl.rd_addr = k_in[11:3];
               end
            end
         end
         FSM_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   assign rsp_tdata = {1'b0, used_ff, start_ff, st_ff};

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request accepted while a response is pending");
   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && st_ff != ST_DONE) |-> start_ff == '0 && !used_ff)
      else $error("nonzero result fields on a failed transaction");
   a_size_range: assert property (@(posedge clock) disable iff (reset)
      size_ff != '0 && size_ff <= SizeWidth'(MapBytes))
      else $error("map size out of range");

endmodule

FILE: tb/sv/bitmap_run_allocator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap run allocator core testbench
// Drives requests against a shadow copy of the unit map. A short stimulus
// table covers the field extremes, every action, bad requests and a full
// map. Random phases follow at several map sizes. Both stream sides idle
// at random but in one quiet phase, and each response is compared field
// by field with the predicted one.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_core_test;
   import bra_pkg::*;

   typedef struct packed {
      logic [12:0] count;
      logic [11:0] bit_index;
      action_type  action;
   } req_type;

   typedef struct packed {
      logic       bit_is_used;
      logic [11:0] start_index;
      status_type status;
   } rsp_type;

   typedef struct {
      action_type  action;
      logic [11:0] bit_index;
      logic [12:0] count;
      logic        known;
      status_type  status;
      logic [11:0] start_index;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [9:0]  csr_wdata = '0;

   logic [7:0]  shadow_map [MapBytes];
   int          bytes_in_use;
   rsp_type     pending_rsps [$];
   int          mismatches = 0;
   int          rsp_seen = 0;
   int          allocs_ok = 0;
   bit          quiet_sink = 1'b0;
   bit          quiet_source = 1'b0;
   int          phase_sizes [] = '{1, 0, 2, 1023, 7, 512, 64};

   bitmap_run_allocator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic rsp_type predict_action(req_type r);
      rsp_type o;
      int      total;
      int      run;
      int      n;
      int      s;
      bit      found;
      o = '{bit_is_used: 1'b0, start_index: '0, status: ST_DONE};
      total = bytes_in_use * 8;
      found = 1'b0;
      run = 0;
      if (r.action == ACT_ALLOC) begin
         if (r.count == 0) begin
            o.status = ST_BAD;
         end else begin
            for (n = 0; n < total; n++) begin
               if (shadow_map[n / 8][n % 8]) begin
                  run = 0;
               end else begin
                  run++;
                  if (run == r.count) begin
                     found = 1'b1;
                     break;
                  end
               end
            end
            if (found) begin
               s = n + 1 - r.count;
               for (int k = s; k <= n; k++) shadow_map[k / 8][k % 8] = 1'b1;
               o.start_index = s[11:0];
               allocs_ok++;
            end else begin
               o.status = ST_NO_ROOM;
            end
         end
      end else if (r.bit_index >= total) begin
         o.status = ST_BAD;
      end else if (r.action == ACT_TEST) begin
         o.bit_is_used = shadow_map[r.bit_index / 8][r.bit_index % 8];
      end else begin
         shadow_map[r.bit_index / 8][r.bit_index % 8] = (r.action == ACT_SET);
      end
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[14:0];
         rsp_seen++;
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response %h", rsp_tdata);
         end else begin
            want = pending_rsps.pop_front();
            if (got !== want || rsp_tdata[15] !== 1'b0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected status %0d start %0d used %0d, got %0d %0d %0d",
                           want.status, want.start_index, want.bit_is_used,
                           got.status, got.start_index, got.bit_is_used);
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= quiet_sink || ($urandom_range(99) >= 11);
   end

   task automatic send_request(req_type r, bit known, status_type st, logic [11:0] si);
      rsp_type p;
      @(negedge clock);
      while (!quiet_source && $urandom_range(99) < 11) @(negedge clock);
      req_tdata <= {5'b0, r};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      p = predict_action(r);
      if (known && (p.status != st || p.start_index != si)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Table row disagrees with prediction: %0d %0d", st, si);
      end
      pending_rsps.push_back(p);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic drain_and_set_size(logic [9:0] value);
      while (pending_rsps.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      bytes_in_use = (value == 0) ? 1 : (value > MapBytes ? MapBytes : value);
   endtask

   task automatic random_request(int units);
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      r.action = action_type'($urandom_range(3));
      r.bit_index = (pick < 85) ? 12'($urandom_range(units - 1)) : 12'($urandom);
      if (pick < 60) r.count = 13'($urandom_range(1, 12));
      else if (pick < 80) r.count = 13'($urandom_range(1, units));
      else r.count = 13'($urandom);
      send_request(r, 1'b0, ST_DONE, '0);
   endtask

   row_type stim_table [] = '{
      '{ACT_TEST,  12'd0,    13'd0,    1'b1, ST_DONE, 12'd0},
      '{ACT_TEST,  12'd4095, 13'd8191, 1'b1, ST_DONE, 12'd0},
      '{ACT_ALLOC, 12'd0,    13'd0,    1'b1, ST_BAD,  12'd0},
      '{ACT_ALLOC, 12'd4095, 13'd4097, 1'b1, ST_NO_ROOM, 12'd0},
      '{ACT_ALLOC, 12'd0,    13'd8191, 1'b1, ST_NO_ROOM, 12'd0},
      '{ACT_ALLOC, 12'd0,    13'd1,    1'b1, ST_DONE, 12'd0},
      '{ACT_ALLOC, 12'd0,    13'd3,    1'b1, ST_DONE, 12'd1},
      '{ACT_TEST,  12'd3,    13'd0,    1'b0, ST_DONE, 12'd0},
      '{ACT_CLEAR, 12'd1,    13'd0,    1'b1, ST_DONE, 12'd0},
      '{ACT_ALLOC, 12'd0,    13'd1,    1'b1, ST_DONE, 12'd1},
      '{ACT_SET,   12'd4095, 13'd0,    1'b1, ST_DONE, 12'd0},
      '{ACT_TEST,  12'd4095, 13'd0,    1'b0, ST_DONE, 12'd0},
      '{ACT_ALLOC, 12'd0,    13'd4091, 1'b1, ST_DONE, 12'd4},
      '{ACT_ALLOC, 12'd0,    13'd1,    1'b1, ST_NO_ROOM, 12'd0},
      '{ACT_CLEAR, 12'd4095, 13'd0,    1'b1, ST_DONE, 12'd0},
      '{ACT_ALLOC, 12'd0,    13'd1,    1'b1, ST_DONE, 12'd4095},
      '{ACT_CLEAR, 12'd2730, 13'd0,    1'b1, ST_DONE, 12'd0},
      '{ACT_TEST,  12'd2730, 13'd0,    1'b0, ST_DONE, 12'd0},
      '{ACT_ALLOC, 12'd0,    13'd1,    1'b1, ST_DONE, 12'd2730}
   };

   initial begin
      req_type r;
      bytes_in_use = MapBytes;
      foreach (shadow_map[i]) shadow_map[i] = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      foreach (stim_table[i]) begin
         r.action = stim_table[i].action;
         r.bit_index = stim_table[i].bit_index;
         r.count = stim_table[i].count;
         send_request(r, stim_table[i].known, stim_table[i].status,
                      stim_table[i].start_index);
      end
      foreach (phase_sizes[p]) begin
         drain_and_set_size(10'(phase_sizes[p]));
         if (bytes_in_use == 1) begin
            for (int b = 0; b < 8; b++) begin
               r.action = ACT_CLEAR;
               r.bit_index = 12'(b);
               r.count = '0;
               send_request(r, 1'b0, ST_DONE, '0);
            end
         end
         quiet_source = (p == 3);
         quiet_sink = (p == 3);
         repeat ((bytes_in_use == MapBytes) ? 50 : 90)
            random_request(bytes_in_use * 8);
         quiet_source = 1'b0;
         quiet_sink = 1'b0;
      end
      while (pending_rsps.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("Covered %0d responses over %0d map size phases, %0d successful allocations.",
               rsp_seen, phase_sizes.size() + 1, allocs_ok);
      if (mismatches == 0 && pending_rsps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #500ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
